// File: rtl/ecs_pkg.sv
// shared types and constants for the eye candidate selector
package ecs_pkg;

   localparam int COORD_BITS = 12;
   localparam int WIDE_BITS = COORD_BITS + 1;
   localparam int AREA_BITS = 2 * COORD_BITS;
   localparam int RAD_BITS = 12;
   localparam int CMP_BITS = (WIDE_BITS > RAD_BITS) ? WIDE_BITS : RAD_BITS;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [RAD_BITS-1:0] MIN_RADIUS_RESET = RAD_BITS'(4);
   localparam logic [RAD_BITS-1:0] MAX_RADIUS_RESET = RAD_BITS'(64);

   typedef enum logic {
      SIDE_LEFT  = 1'b0,
      SIDE_RIGHT = 1'b1
   } side_type;

   typedef enum logic {
      STATUS_FOUND  = 1'b0,
      STATUS_FAILED = 1'b1
   } status_type;

   typedef enum logic {
      CSR_MIN_RADIUS = 1'b0,
      CSR_MAX_RADIUS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] face_left;
      logic [COORD_BITS-1:0] face_top;
      logic [COORD_BITS-1:0] face_width;
      logic [COORD_BITS-1:0] face_height;
      logic                  eye_side;
      logic [COORD_BITS-1:0] box_left;
      logic [COORD_BITS-1:0] box_top;
      logic [COORD_BITS-1:0] box_width;
      logic [COORD_BITS-1:0] box_height;
      logic                  first_of_set;
      logic                  last_of_set;
   } req_type;

   typedef struct packed {
      logic                 status;
      logic [WIDE_BITS-1:0] left_eye_x;
      logic [WIDE_BITS-1:0] left_eye_y;
      logic [WIDE_BITS-1:0] right_eye_x;
      logic [WIDE_BITS-1:0] right_eye_y;
   } rsp_type;

   typedef struct packed {
      logic [RAD_BITS-1:0] min_eye_radius;
      logic [RAD_BITS-1:0] max_eye_radius;
   } cfg_type;

   typedef struct packed {
      logic                 keep;
      logic                 eye_side;
      logic [AREA_BITS-1:0] area;
      logic [WIDE_BITS-1:0] mid_x;
      logic [WIDE_BITS-1:0] mid_y;
      logic                 first_of_set;
      logic                 last_of_set;
   } cand_type;

endpackage

// File: rtl/ecs_front.sv
// front end: checks a candidate box against the face and the radius limits
module ecs_front
   import ecs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 push,
   input  req_type              req_data,
   input  logic                 queue_full,
   output logic                 cand_valid,
   output cand_type             cand
);

   logic [WIDE_BITS-1:0] face_midy;
   logic [WIDE_BITS-1:0] face_half;
   logic [WIDE_BITS-1:0] face_right;
   logic [WIDE_BITS-1:0] face_left_w;
   logic [WIDE_BITS-1:0] mid_x;
   logic [WIDE_BITS-1:0] mid_y;
   logic [WIDE_BITS-1:0] size_sum;
   logic [CMP_BITS-1:0]  radius;
   logic [CMP_BITS-1:0]  min_radius;
   logic [CMP_BITS-1:0]  max_radius;
   logic                 keep_common;
   logic                 keep_side;
   logic [AREA_BITS-1:0] area_ff;
   logic [AREA_BITS-1:0] area_in;
   cand_type             cand_ff;
   cand_type             cand_in;
   logic                 valid_ff;
   logic                 valid_in;

   assign face_midy = WIDE_BITS'(req_data.face_top) + WIDE_BITS'(req_data.face_height >> 1);
   assign face_half = WIDE_BITS'(req_data.face_left) + WIDE_BITS'(req_data.face_width >> 1);
   assign face_right = WIDE_BITS'(req_data.face_left) + WIDE_BITS'(req_data.face_width);
   assign face_left_w = WIDE_BITS'(req_data.face_left);
   assign mid_x = WIDE_BITS'(req_data.box_left) + WIDE_BITS'(req_data.box_width >> 1);
   assign mid_y = WIDE_BITS'(req_data.box_top) + WIDE_BITS'(req_data.box_height >> 1);
   assign size_sum = WIDE_BITS'(req_data.box_width) + WIDE_BITS'(req_data.box_height);
   assign radius = CMP_BITS'(size_sum >> 1);
   assign min_radius = CMP_BITS'(cfg.min_eye_radius);
   assign max_radius = CMP_BITS'(cfg.max_eye_radius);

   assign keep_common = (radius <= max_radius) && (radius >= min_radius)
      && (mid_y <= face_midy) && (mid_y >= (face_midy >> 1));

   always_comb begin
      unique case (side_type'(req_data.eye_side))
         SIDE_RIGHT: keep_side = (mid_x < face_right) && (mid_x > face_half);
         SIDE_LEFT:  keep_side = (mid_x < face_half) && (mid_x > face_left_w);
         default:    keep_side = 1'b0;
      endcase
   end

   assign area_in = AREA_BITS'(req_data.box_width) * AREA_BITS'(req_data.box_height);

   always_comb begin
      cand_in.keep = keep_common && keep_side;
      cand_in.eye_side = req_data.eye_side;
      cand_in.area = '0;
      cand_in.mid_x = mid_x;
      cand_in.mid_y = mid_y;
      cand_in.first_of_set = req_data.first_of_set;
      cand_in.last_of_set = req_data.last_of_set;
   end

   // stage register in front of the queue; full holds it
   assign valid_in = push && !queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (valid_in) begin
         cand_ff <= cand_in;
         area_ff <= area_in;
      end
   end

   always_comb begin
      cand = cand_ff;
      cand.area = area_ff;
   end

   assign cand_valid = valid_ff;

endmodule

// File: rtl/ecs_queue.sv
// short queue of classified candidates between front and back
module ecs_queue
   import ecs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   input  cand_type wr_data,
   output logic     almost_full,
   input  logic     rd_ready,
   output logic     rd_valid,
   output cand_type rd_data
);

   cand_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff;
   logic [QUEUE_CNT_BITS-1:0] count_in;
   logic                      do_rd;

   assign rd_valid = (count_ff != '0);
   assign do_rd = rd_valid && rd_ready;
   assign rd_data = mem_ff[rd_ptr_ff];

   // one slot is held back for the request sitting in the front stage
   assign almost_full = (count_ff >= QUEUE_CNT_BITS'(QUEUE_DEPTH - 1)) && !do_rd
      || (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH)) && wr_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_valid) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QUEUE_CNT_BITS'(wr_valid) - QUEUE_CNT_BITS'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (wr_valid) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/ecs_back.sv
// back end: keeps the smallest kept box per side and builds the result
module ecs_back
   import ecs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     cand_valid,
   input  cand_type cand,
   output logic     cand_ready,
   output logic     empty,
   input  logic     pop,
   output rsp_type  rsp_data
);

   logic                 left_found_ff;
   logic                 left_found_in;
   logic [AREA_BITS-1:0] left_area_ff;
   logic [AREA_BITS-1:0] left_area_in;
   logic [WIDE_BITS-1:0] left_cx_ff;
   logic [WIDE_BITS-1:0] left_cx_in;
   logic [WIDE_BITS-1:0] left_cy_ff;
   logic [WIDE_BITS-1:0] left_cy_in;
   logic                 right_found_ff;
   logic                 right_found_in;
   logic [AREA_BITS-1:0] right_area_ff;
   logic [AREA_BITS-1:0] right_area_in;
   logic [WIDE_BITS-1:0] right_cx_ff;
   logic [WIDE_BITS-1:0] right_cx_in;
   logic [WIDE_BITS-1:0] right_cy_ff;
   logic [WIDE_BITS-1:0] right_cy_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   rsp_type              out_ff;
   rsp_type              out_in;
   logic                 take;
   logic                 lf;
   logic                 rf;
   logic [AREA_BITS-1:0] la;
   logic [AREA_BITS-1:0] ra;
   logic                 upd_left;
   logic                 upd_right;

   assign cand_ready = !cand.last_of_set || !out_valid_ff || pop;
   assign take = cand_valid && cand_ready;

   always_comb begin
      lf = cand.first_of_set ? 1'b0 : left_found_ff;
      la = cand.first_of_set ? '0 : left_area_ff;
      rf = cand.first_of_set ? 1'b0 : right_found_ff;
      ra = cand.first_of_set ? '0 : right_area_ff;
      upd_left = cand.keep && (side_type'(cand.eye_side) == SIDE_LEFT)
         && (!lf || (cand.area < la));
      upd_right = cand.keep && (side_type'(cand.eye_side) == SIDE_RIGHT)
         && (!rf || (cand.area < ra));

      left_found_in = lf || upd_left;
      left_area_in = upd_left ? cand.area : la;
      left_cx_in = upd_left ? cand.mid_x : (cand.first_of_set ? '0 : left_cx_ff);
      left_cy_in = upd_left ? cand.mid_y : (cand.first_of_set ? '0 : left_cy_ff);
      right_found_in = rf || upd_right;
      right_area_in = upd_right ? cand.area : ra;
      right_cx_in = upd_right ? cand.mid_x : (cand.first_of_set ? '0 : right_cx_ff);
      right_cy_in = upd_right ? cand.mid_y : (cand.first_of_set ? '0 : right_cy_ff);

      if (left_found_in && right_found_in) begin
         out_in.status = STATUS_FOUND;
         out_in.left_eye_x = left_cx_in;
         out_in.left_eye_y = left_cy_in;
         out_in.right_eye_x = right_cx_in;
         out_in.right_eye_y = right_cy_in;
      end else begin
         out_in = '0;
         out_in.status = STATUS_FAILED;
      end

      out_valid_in = out_valid_ff && !pop;
      if (take && cand.last_of_set) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_found_ff <= 1'b0;
         left_area_ff <= '0;
         left_cx_ff <= '0;
         left_cy_ff <= '0;
         right_found_ff <= 1'b0;
         right_area_ff <= '0;
         right_cx_ff <= '0;
         right_cy_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            if (cand.last_of_set) begin
               left_found_ff <= 1'b0;
               left_area_ff <= '0;
               left_cx_ff <= '0;
               left_cy_ff <= '0;
               right_found_ff <= 1'b0;
               right_area_ff <= '0;
               right_cx_ff <= '0;
               right_cy_ff <= '0;
            end else begin
               left_found_ff <= left_found_in;
               left_area_ff <= left_area_in;
               left_cx_ff <= left_cx_in;
               left_cy_ff <= left_cy_in;
               right_found_ff <= right_found_in;
               right_area_ff <= right_area_in;
               right_cx_ff <= right_cx_in;
               right_cy_ff <= right_cy_in;
            end
         end
      end
      if (take && cand.last_of_set) begin
         out_ff <= out_in;
      end
   end

   assign empty = !out_valid_ff;
   assign rsp_data = out_ff;

endmodule

// File: rtl/eye_candidate_select.sv
// top level of the eye candidate selector with its register port
//
// Candidate eye boxes for one face stream in as requests, one per clock while
// full is low. The front end checks each box against the radius limits and the
// face geometry and computes its area in one registered stage; a two-entry queue
// carries the classified request to the back end, which updates the smallest
// box per side. A request marked last of set produces one result, passing the
// front register, the queue and the result register; the single result register
// stalls the back end only when a new result is due while the previous one waits.
// Registers: min_eye_radius at byte address 0, max_eye_radius at byte address 4;
// write them only while no request is in flight.
module eye_candidate_select
   import ecs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  req_type                  req_data,
   output logic                     empty,
   input  logic                     pop,
   output rsp_type                  rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     csr_write;
   logic     cand_valid;
   cand_type cand;
   logic     q_rd_valid;
   cand_type q_rd_data;
   logic     back_ready;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(paddr[2]))
            CSR_MIN_RADIUS: cfg_in.min_eye_radius = pwdata[RAD_BITS-1:0];
            CSR_MAX_RADIUS: cfg_in.max_eye_radius = pwdata[RAD_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index_type'(paddr[2]))
         CSR_MIN_RADIUS: prdata = CSR_DATA_BITS'(cfg_ff.min_eye_radius);
         CSR_MAX_RADIUS: prdata = CSR_DATA_BITS'(cfg_ff.max_eye_radius);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_eye_radius <= MIN_RADIUS_RESET;
         cfg_ff.max_eye_radius <= MAX_RADIUS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ecs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .push       (push),
      .req_data   (req_data),
      .queue_full (full),
      .cand_valid (cand_valid),
      .cand       (cand)
   );

   ecs_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .wr_valid    (cand_valid),
      .wr_data     (cand),
      .almost_full (full),
      .rd_ready    (back_ready),
      .rd_valid    (q_rd_valid),
      .rd_data     (q_rd_data)
   );

   ecs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cand_valid (q_rd_valid),
      .cand       (q_rd_data),
      .cand_ready (back_ready),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule
